// ===== rtl/stbs_pkg.sv =====
// Package for the sorted table binary search unit: widths, types and the
// request structs passed between the sequencer and the table memory.
// No dependencies.
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 40;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 11;
    localparam int IN_IDX_W    = 10;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [COUNT_W-1:0]   t_count;

    typedef struct packed {
        logic en;
        t_idx addr;
        t_key data;
    } t_wr_req;

    typedef struct packed {
        logic en;
        t_idx addr;
    } t_rd_req;

endpackage

// ===== rtl/stbs_table.sv =====
// Key table: one synchronous memory with one write and one read port.
// Read data is registered. Depends on stbs_pkg.
module stbs_table (
    input  logic             i_clk,
    input  stbs_pkg::t_wr_req i_wr,
    input  stbs_pkg::t_rd_req i_rd,
    output stbs_pkg::t_key    o_rd_data
);
    import stbs_pkg::*;

    t_key r_mem [TABLE_DEPTH];
    t_key r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/stbs_ctrl.sv =====
// Search sequencer: holds the entry count, issues table writes for loads
// and walks the probe interval for searches. Depends on stbs_pkg.
module stbs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [stbs_pkg::IN_IDX_W-1:0] i_entry_index,
    input  stbs_pkg::t_key                i_entry_value,
    input  stbs_pkg::t_key                i_search_key,
    input  logic                          i_cfg_we,
    input  logic [stbs_pkg::CFG_W-1:0]    i_cfg_wdata,
    output stbs_pkg::t_wr_req             o_wr,
    output stbs_pkg::t_rd_req             o_rd,
    input  stbs_pkg::t_key                i_rd_data,
    output logic                          o_done,
    output logic                          o_found
);
    import stbs_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_ISSUE   = 2'd1;
    localparam logic [1:0] ST_COMPARE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CFG_W-1:0] r_entry_count;
    t_count           r_lo, n_lo;
    t_count           r_up, n_up;
    t_idx             r_mid, n_mid;
    t_key             r_key, n_key;
    logic             r_done, n_done;
    logic             r_found, n_found;

    logic             accept;
    t_count           count_sat;
    logic [COUNT_W:0] mid_sum;
    t_idx             mid;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // A count above the table depth covers the whole table.
    assign count_sat = (32'(r_entry_count) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH)
                                                         : COUNT_W'(r_entry_count);

    // Lower midpoint of the inclusive interval [lo, up-1]; only used when lo < up.
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_up} - (COUNT_W+1)'(1);
    assign mid     = mid_sum[IDX_W:1];

    always_comb begin
        o_wr.en   = accept && (i_command == CMD_LOAD)
                    && (32'(i_entry_index) < TABLE_DEPTH);
        o_wr.addr = IDX_W'(i_entry_index);
        o_wr.data = i_entry_value;
        o_rd.en   = (r_state == ST_ISSUE) && (r_lo < r_up);
        o_rd.addr = mid;
    end

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_up    = r_up;
        n_mid   = r_mid;
        n_key   = r_key;
        n_done  = 1'b0;
        n_found = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_SEARCH) begin
                        n_state = ST_ISSUE;
                        n_lo    = '0;
                        n_up    = count_sat;
                        n_key   = i_search_key;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            ST_ISSUE: begin
                if (r_lo < r_up) begin
                    n_mid   = mid;
                    n_state = ST_COMPARE;
                end else begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_COMPARE: begin
                priority if (i_rd_data == r_key) begin
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_rd_data > r_key) begin
                    n_up    = COUNT_W'(r_mid);
                    n_state = ST_ISSUE;
                end else begin
                    n_lo    = COUNT_W'(r_mid) + COUNT_W'(1);
                    n_state = ST_ISSUE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_up    <= n_up;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_found <= n_found;
    end

    assign o_done  = r_done;
    assign o_found = r_found;

endmodule

// ===== rtl/sorted_table_binary_search_unit.sv =====
// Top level of the sorted table binary search unit: sequencer and key table.
// Depends on stbs_pkg, stbs_ctrl and stbs_table.
//
//   channel   handshake            payload
//   command   start / busy         i_command, i_entry_index, i_entry_value, i_search_key
//   config    i_cfg_we             i_cfg_wdata (entry count)
//   result    o_done (one cycle)   o_found
//
// A load writes the table at the transfer edge; its result is strobed in the cycle after.
// A search repeats a probe, a table read issued in ST_ISSUE and registered in the table,
// followed by the compare in ST_COMPARE, until a hit or until the interval is empty.
// Synchronous active-low reset clears the state and the entry count; the table
// itself is not cleared. The receiver cannot stall, so each result is shown once.
module sorted_table_binary_search_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [stbs_pkg::IN_IDX_W-1:0] i_entry_index,
    input  stbs_pkg::t_key                i_entry_value,
    input  stbs_pkg::t_key                i_search_key,
    input  logic                          i_cfg_we,
    input  logic [stbs_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                          o_done,
    output logic                          o_found
);
    import stbs_pkg::*;

    t_wr_req wr;
    t_rd_req rd;
    t_key    rd_data;

    stbs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_wr          (wr),
        .o_rd          (rd),
        .i_rd_data     (rd_data),
        .o_done        (o_done),
        .o_found       (o_found)
    );

    stbs_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

endmodule

// ===== bench/tb_sorted_table_binary_search_unit.sv =====
// Self-checking testbench for sorted_table_binary_search_unit: load and search
// commands with random gaps, checked against an in-bench lookup predictor.
// Depends on stbs_pkg and the unit's RTL.
module tb_sorted_table_binary_search_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    typedef struct {
        logic is_search;
        t_key key;
        logic found;
    } t_lookup_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_command;
    logic [IN_IDX_W-1:0] i_entry_index;
    t_key               i_entry_value;
    t_key               i_search_key;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic               o_done;
    logic               o_found;

    // Mirror of the key table and the entry count, updated on each load and count write.
    t_key               key_table [0:TABLE_DEPTH-1];
    logic               key_loaded [0:TABLE_DEPTH-1];
    logic [CFG_W-1:0]   active_count;
    t_lookup_result     pending_lookups [$];
    int                 fail_count = 0;
    int                 burst_left = 0;

    sorted_table_binary_search_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_found       (o_found)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic t_key rand_key();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[KEY_WIDTH-1:0];
    endfunction

    // Binary search over the mirrored table; a count above the depth saturates.
    function automatic logic lookup_key(t_key key);
        int span;
        int lo;
        int hi;
        int mid;
        span = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
        lo = 0;
        hi = span - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key_table[mid] > key) begin
                hi = mid - 1;
            end else if (key_table[mid] < key) begin
                lo = mid + 1;
            end else begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // True when every probe of a search for the key lands on a loaded entry.
    function automatic logic probes_loaded(t_key key);
        int span;
        int lo;
        int hi;
        int mid;
        span = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
        lo = 0;
        hi = span - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (!key_loaded[mid]) begin
                return 1'b0;
            end
            if (key_table[mid] > key) begin
                hi = mid - 1;
            end else if (key_table[mid] < key) begin
                lo = mid + 1;
            end else begin
                return 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // Mostly keys held in the searched range or their neighbours, some random.
    // Only keys whose every probe lands on a loaded entry are returned.
    function automatic t_key pick_search_key();
        int   span;
        int   r;
        int   idx;
        t_key k;
        span = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
        for (int attempt = 0; attempt < 64; attempt++) begin
            r   = $urandom_range(0, 99);
            idx = (span == 0) ? 0 : $urandom_range(0, span - 1);
            if (span == 0 || r < 15 || !key_loaded[idx]) begin
                k = rand_key();
            end else begin
                k = key_table[idx];
                if (r < 30) begin
                    k = k + 1'b1;
                end else if (r < 45) begin
                    k = k - 1'b1;
                end
            end
            if (probes_loaded(k)) begin
                return k;
            end
        end
        // Key zero only ever moves towards index zero, along loaded entries.
        return '0;
    endfunction

    // Sender: bursts of random length separated by random gaps, sometimes none.
    task automatic issue_command(logic cmd, int idx, t_key val, t_key key);
        int idle_gap;
        t_lookup_result exp_item;
        idle_gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
        burst_left--;
        if (idle_gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (idle_gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= IN_IDX_W'(idx);
        i_entry_value <= val;
        i_search_key  <= key;
        do @(posedge i_clk); while (busy);
        exp_item.is_search = (cmd == CMD_SEARCH);
        if (cmd == CMD_LOAD) begin
            key_table[idx]  = val;
            key_loaded[idx] = 1'b1;
            exp_item.key    = val;
            exp_item.found  = 1'b0;
        end else begin
            exp_item.key   = key;
            exp_item.found = lookup_key(key);
        end
        pending_lookups = {pending_lookups, exp_item};
    endtask

    task automatic load_entry(int idx, t_key val);
        issue_command(CMD_LOAD, idx, val, rand_key());
    endtask

    task automatic search_for(t_key key);
        issue_command(CMD_SEARCH, $urandom_range(0, TABLE_DEPTH - 1), rand_key(), key);
    endtask

    // The count is only changed once every outstanding transfer has completed.
    task automatic set_entry_count(int n);
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (pending_lookups.size() != 0 || busy);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(n);
        active_count = CFG_W'(n);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Ascending keys from index zero; step size chosen so the sum stays in range.
    task automatic fill_sorted(int n);
        logic [63:0] step_max;
        logic [63:0] v;
        step_max = ((64'd1 << KEY_WIDTH) - 1) / n;
        step_max = step_max >> $urandom_range(0, 30);
        v = {$urandom, $urandom} % (step_max + 1);
        for (int i = 0; i < n; i++) begin
            load_entry(i, v[KEY_WIDTH-1:0]);
            v = v + ({$urandom, $urandom} % (step_max + 1));
        end
    endtask

    // Loads only the entries on the lowest and the highest probe path of a
    // full-depth search, with values rising with the index.
    task automatic fill_outer_paths();
        logic [63:0] step;
        logic [63:0] base;
        logic [63:0] v;
        int          lo;
        int          hi;
        int          mid;
        step = (((64'd1 << KEY_WIDTH) - 1) / TABLE_DEPTH) >> $urandom_range(0, 20);
        base = {$urandom, $urandom} % (step + 1);
        lo = 0;
        hi = TABLE_DEPTH - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            v   = base + 64'(mid) * step;
            load_entry(mid, v[KEY_WIDTH-1:0]);
            hi  = mid - 1;
        end
        lo = 0;
        hi = TABLE_DEPTH - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            v   = base + 64'(mid) * step;
            load_entry(mid, v[KEY_WIDTH-1:0]);
            lo  = mid + 1;
        end
    endtask

    task automatic test_empty_table();
        search_for('0);
        search_for('1);
        search_for(rand_key());
        set_entry_count(0);
        search_for(rand_key());
    endtask

    task automatic test_directed_lookup();
        load_entry(0, '0);
        load_entry(1, 40'd1);
        load_entry(2, 40'd5);
        load_entry(3, 40'd1000);
        load_entry(4, 40'h00_0010_0000);
        load_entry(5, 40'h80_0000_0000);
        load_entry(6, 40'hFF_FFFF_FFFE);
        load_entry(7, '1);
        load_entry(TABLE_DEPTH - 1, '1);
        set_entry_count(8);
        search_for('0);
        search_for('1);
        search_for(40'd5);
        search_for(40'h80_0000_0000);
        search_for(40'd1000);
        search_for(40'd2);
        search_for(40'd6);
        search_for(40'hFF_FFFF_FFFD);
        set_entry_count(1);
        search_for('0);
        search_for(40'd1);
    endtask

    task automatic test_full_table();
        fill_outer_paths();
        set_entry_count(TABLE_DEPTH);
        search_for(key_table[0]);
        search_for(key_table[TABLE_DEPTH-1]);
        search_for('1);
        search_for('0);
        repeat (30) search_for(pick_search_key());
        // Counts beyond the depth must behave as a full table.
        set_entry_count((1 << CFG_W) - 1);
        repeat (10) search_for(pick_search_key());
        set_entry_count(TABLE_DEPTH + 1);
        repeat (5) search_for(pick_search_key());
    endtask

    task automatic test_unsorted_table();
        for (int i = 0; i < 16; i++) begin
            load_entry(i, rand_key());
        end
        set_entry_count(16);
        for (int i = 0; i < 16; i++) begin
            search_for(key_table[i]);
        end
        repeat (5) search_for(rand_key());
    endtask

    task automatic test_random_mix();
        int issued;
        int n;
        int r;
        issued = 0;
        while (issued < 370) begin
            r = $urandom_range(0, 15);
            if (r == 0) begin
                n = 0;
            end else if (r == 1) begin
                n = $urandom_range(TABLE_DEPTH + 1, (1 << CFG_W) - 1);
            end else if (r == 2) begin
                n = $urandom_range(65, 192);
            end else begin
                n = $urandom_range(1, 64);
            end
            if (n > 0 && n <= TABLE_DEPTH) begin
                fill_sorted(n);
                issued += n;
            end
            set_entry_count(n);
            repeat ($urandom_range(5, 25)) begin
                // A stray load now and then may leave the table out of order.
                if ($urandom_range(0, 9) == 0) begin
                    load_entry($urandom_range(0, TABLE_DEPTH - 1), rand_key());
                end else begin
                    search_for(pick_search_key());
                end
                issued++;
            end
        end
    endtask

    // Each strobed result is taken at the edge that ends its cycle.
    always @(posedge i_clk) begin
        t_lookup_result exp_item;
        if (i_rst_n && o_done) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: unexpected result transfer, found %0b", $time, o_found);
                fail_count++;
            end else begin
                exp_item = pending_lookups.pop_front();
                if (o_found !== exp_item.found) begin
                    $display("%0t: %s %h: expected found %0b, actual %0b", $time,
                             exp_item.is_search ? "search" : "load", exp_item.key,
                             exp_item.found, o_found);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_command     = CMD_LOAD;
        i_entry_index = '0;
        i_entry_value = '0;
        i_search_key  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        active_count  = '0;
        foreach (key_loaded[i]) begin
            key_loaded[i] = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_directed_lookup();
        test_full_table();
        test_unsorted_table();
        test_random_mix();

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending_lookups.size() == 0) begin
            $display("tb_sorted_table_binary_search_unit: PASS");
        end else begin
            $display("tb_sorted_table_binary_search_unit: FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_sorted_table_binary_search_unit: FAIL");
        $finish;
    end

endmodule
